@@ design/isodns_pkg.sv @@
package isodns_pkg;

  // Default sector size and the longest component the compare window covers.
  localparam int unsigned SECTOR_BYTES_DEF = 2048;
  localparam int unsigned MAX_NAME_CHARS   = 32;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DIR_SIZE  = 3'd0;
  localparam logic [2:0] CFG_NAME_LEN  = 3'd1;
  localparam logic [2:0] CFG_CHARS_0   = 3'd2;
  localparam logic [2:0] CFG_CHARS_8   = 3'd3;
  localparam logic [2:0] CFG_CHARS_16  = 3'd4;
  localparam logic [2:0] CFG_CHARS_24  = 3'd5;

  // Byte offsets inside a directory record.
  localparam logic [7:0] POS_SECTOR_LO = 8'd2;
  localparam logic [7:0] POS_SECTOR_HI = 8'd5;
  localparam logic [7:0] POS_SIZE_LO   = 8'd10;
  localparam logic [7:0] POS_SIZE_HI   = 8'd13;
  localparam logic [7:0] POS_FLAGS     = 8'd25;
  localparam logic [7:0] POS_NAME_LEN  = 8'd32;
  localparam logic [7:0] POS_NAME      = 8'd33;

  localparam logic [7:0] CHAR_SEMI     = 8'h3B;
  localparam logic [7:0] CHAR_LC_A     = 8'h61;
  localparam logic [7:0] CHAR_LC_Z     = 8'h7A;
  localparam logic [7:0] CASE_DELTA    = 8'h20;
  localparam int unsigned DIR_FLAG_BIT = 1;

  typedef struct packed {
    logic [31:0]  dir_size;
    logic [5:0]   name_len;
    logic [255:0] name_chars;
  } cfg_t;

  typedef struct packed {
    logic        found;
    logic [31:0] sector;
    logic [31:0] bytes;
    logic        is_dir;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      r = c - CASE_DELTA;
    end
    return r;
  endfunction

endpackage

@@ design/isodns_name_cmp.sv @@
module isodns_name_cmp
  import isodns_pkg::*;
(
  input  logic [7:0]   char_i,
  input  logic [7:0]   idx_i,
  input  logic [5:0]   name_len_i,
  input  logic [255:0] name_chars_i,
  output logic         mismatch_o
);

  logic [7:0] wanted;

  // Pick the wanted character by its low five index bits.
  assign wanted = name_chars_i[{idx_i[4:0], 3'b000} +: 8];

  assign mismatch_o = (idx_i >= {2'b00, name_len_i})
                   || (idx_i >= 8'(MAX_NAME_CHARS))
                   || (fold_case(char_i) != fold_case(wanted));

endmodule

@@ design/isodns_parser.sv @@
module isodns_parser
  import isodns_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic [7:0] byte_i,
  input  logic    first_i,
  input  cfg_t    cfg_i,
  output logic    emit_o,
  output result_t result_o
);

  localparam int unsigned SposW = $clog2(SECTOR_BYTES);
  localparam logic [SposW-1:0] SposLast = SposW'(SECTOR_BYTES - 1);

  logic [31:0]      offset_q, offset_d;
  logic [SposW-1:0] spos_q, spos_d;
  logic [7:0]       rpos_q, rpos_d;
  logic [7:0]       rlen_q, rlen_d;
  logic             skip_q, skip_d;
  logic [31:0]      sector_q, sector_d;
  logic [31:0]      size_q, size_d;
  logic             dir_q, dir_d;
  logic [7:0]       nl_q, nl_d;
  logic [7:0]       fchar_q, fchar_d;
  logic             match_q, match_d;
  logic             vmark_q, vmark_d;
  logic             done_q, done_d;

  logic [7:0] name_idx;
  logic       char_mismatch;

  assign name_idx = rpos_q - POS_NAME;

  isodns_name_cmp u_cmp (
    .char_i       (byte_i),
    .idx_i        (name_idx),
    .name_len_i   (cfg_i.name_len),
    .name_chars_i (cfg_i.name_chars),
    .mismatch_o   (char_mismatch)
  );

  always_comb begin
    logic       boundary;
    logic       decide;
    logic       dot;
    logic [7:0] p;
    logic [7:0] eff;
    logic       at_bound;
    logic       stop;

    offset_d = offset_q;
    spos_d   = spos_q;
    rpos_d   = rpos_q;
    rlen_d   = rlen_q;
    skip_d   = skip_q;
    sector_d = sector_q;
    size_d   = size_q;
    dir_d    = dir_q;
    nl_d     = nl_q;
    fchar_d  = fchar_q;
    match_d  = match_q;
    vmark_d  = vmark_q;
    done_d   = done_q;
    emit_o   = 1'b0;
    result_o = '0;
    boundary = 1'b0;
    decide   = 1'b0;
    dot      = 1'b0;
    p        = rpos_q;
    eff      = '0;
    at_bound = 1'b0;
    stop     = 1'b0;

    if (step_i) begin
      if (first_i) begin
        offset_d = '0;
        spos_d   = '0;
        rpos_d   = '0;
        rlen_d   = '0;
        skip_d   = 1'b0;
        match_d  = 1'b1;
        vmark_d  = 1'b0;
        done_d   = 1'b0;
        p        = '0;
      end else if (done_q) begin
        stop = 1'b1;
      end

      if (!stop) begin
        if (skip_d) begin
          if (offset_d != '1) begin
            offset_d = offset_d + 32'd1;
            spos_d   = (spos_d == SposLast) ? '0 : spos_d + SposW'(1);
          end
          if (spos_d == '0 || offset_d == '1) begin
            skip_d   = 1'b0;
            boundary = 1'b1;
          end
        end else if (p == '0) begin
          if (offset_d >= cfg_i.dir_size) begin
            emit_o = 1'b1;
            done_d = 1'b1;
          end else begin
            if (offset_d != '1) begin
              offset_d = offset_d + 32'd1;
              spos_d   = (spos_d == SposLast) ? '0 : spos_d + SposW'(1);
            end
            at_bound = (spos_d == '0) || (offset_d == '1);
            if (byte_i == '0) begin
              if (!at_bound) begin
                skip_d = 1'b1;
              end else begin
                boundary = 1'b1;
              end
            end else begin
              rlen_d   = byte_i;
              sector_d = '0;
              size_d   = '0;
              dir_d    = 1'b0;
              nl_d     = '0;
              fchar_d  = '0;
              match_d  = 1'b1;
              vmark_d  = 1'b0;
              if (byte_i == 8'd1) begin
                boundary = 1'b1;
              end else begin
                rpos_d = 8'd1;
              end
            end
          end
        end else begin
          // Inside a record: capture fields and compare name characters.
          if (p >= POS_SECTOR_LO && p <= POS_SECTOR_HI) begin
            sector_d[{p[1:0] - 2'd2, 3'b000} +: 8] = byte_i;
          end else if (p >= POS_SIZE_LO && p <= POS_SIZE_HI) begin
            size_d[{p[1:0] - 2'd2, 3'b000} +: 8] = byte_i;
          end else if (p == POS_FLAGS) begin
            dir_d = byte_i[DIR_FLAG_BIT];
          end else if (p == POS_NAME_LEN) begin
            nl_d = byte_i;
            if (byte_i == '0) begin
              decide = 1'b1;
            end
          end else if (p >= POS_NAME && {1'b0, p} <= {1'b0, POS_NAME_LEN} + {1'b0, nl_q}) begin
            if (name_idx == '0) begin
              fchar_d = byte_i;
            end
            if (nl_q >= 8'd2 && name_idx == nl_q - 8'd2 && byte_i == CHAR_SEMI) begin
              vmark_d = 1'b1;
            end else if (vmark_q && name_idx == nl_q - 8'd1) begin
              // version digit: not compared
            end else if (char_mismatch) begin
              match_d = 1'b0;
            end
            if ({1'b0, p} == {1'b0, POS_NAME_LEN} + {1'b0, nl_q}) begin
              decide = 1'b1;
            end
          end

          if (offset_d != '1) begin
            offset_d = offset_d + 32'd1;
            spos_d   = (spos_d == SposLast) ? '0 : spos_d + SposW'(1);
          end

          dot = (nl_d == 8'd1) && (fchar_d <= 8'd1);
          eff = vmark_d ? nl_d - 8'd2 : nl_d;
          if (decide && !dot && match_d && eff == {2'b00, cfg_i.name_len}
              && cfg_i.name_len <= 6'(MAX_NAME_CHARS)) begin
            emit_o          = 1'b1;
            done_d          = 1'b1;
            result_o.found  = 1'b1;
            result_o.sector = sector_d;
            result_o.bytes  = size_d;
            result_o.is_dir = dir_d;
          end else if ({1'b0, p} + 9'd1 >= {1'b0, rlen_q}) begin
            rpos_d   = '0;
            boundary = 1'b1;
          end else begin
            rpos_d = p + 8'd1;
          end
        end

        if (!emit_o && boundary && offset_d >= cfg_i.dir_size) begin
          emit_o = 1'b1;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      spos_q   <= '0;
      rpos_q   <= '0;
      rlen_q   <= '0;
      skip_q   <= 1'b0;
      sector_q <= '0;
      size_q   <= '0;
      dir_q    <= 1'b0;
      nl_q     <= '0;
      fchar_q  <= '0;
      match_q  <= 1'b1;
      vmark_q  <= 1'b0;
      done_q   <= 1'b1;
    end else begin
      offset_q <= offset_d;
      spos_q   <= spos_d;
      rpos_q   <= rpos_d;
      rlen_q   <= rlen_d;
      skip_q   <= skip_d;
      sector_q <= sector_d;
      size_q   <= size_d;
      dir_q    <= dir_d;
      nl_q     <= nl_d;
      fchar_q  <= fchar_d;
      match_q  <= match_d;
      vmark_q  <= vmark_d;
      done_q   <= done_d;
    end
  end

endmodule

@@ design/iso9660_directory_name_search_core.sv @@
// Directory record lookup for ISO9660. Feed the bytes of one directory
// extent, one byte per item, with the first byte marked by tuser; the core
// walks the records (length byte, extent sector, size, flags, name), skips
// padding to the next sector boundary and the self and parent entries, and
// compares each name to the configured path component without regard to
// letter case, accepting a trailing ";N" version suffix. It returns one item
// per scan: found with the entry's sector, size and directory flag, or
// not-found once a record boundary reaches the configured extent size.
// Bytes that arrive after the result and before the next first byte are
// dropped. The core takes one byte every cycle unless its result register
// is full and stalled; one input register feeds the record parser, and one
// result register offers its result. Write the
// configuration registers only while no scan is in flight.
module iso9660_directory_name_search_core
  import isodns_pkg::*;
#(
  parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte stream in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] dir_byte
  input  logic        s_axis_tuser,   // [0] first_of_scan
  // Result out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] entry_sector, [63:32] entry_bytes,
                                      // [64] entry_is_dir, [71:65] zero
  output logic        m_axis_tuser,   // [0] found
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  cfg_t    cfg_q;
  logic    in_valid_q;
  logic [7:0] in_byte_q;
  logic    in_first_q;
  logic    out_valid_q;
  result_t out_q;
  logic    advance;
  logic    emit;
  result_t result;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dir_size   <= '0;
      cfg_q.name_len   <= 6'd1;
      cfg_q.name_chars <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIR_SIZE: cfg_q.dir_size              <= cfg_wdata_i[31:0];
        CFG_NAME_LEN: cfg_q.name_len              <= cfg_wdata_i[5:0];
        CFG_CHARS_0:  cfg_q.name_chars[63:0]      <= cfg_wdata_i;
        CFG_CHARS_8:  cfg_q.name_chars[127:64]    <= cfg_wdata_i;
        CFG_CHARS_16: cfg_q.name_chars[191:128]   <= cfg_wdata_i;
        CFG_CHARS_24: cfg_q.name_chars[255:192]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Process the held item whenever the result register has room.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser;
    end
  end

  isodns_parser #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .first_i  (in_first_q),
    .cfg_i    (cfg_q),
    .emit_o   (emit),
    .result_o (result)
  );

  // Result register: load on emit, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.found;
  assign m_axis_tdata  = {7'd0, out_q.is_dir, out_q.bytes, out_q.sector};

endmodule

@@ design/isodns_checker.sv @@
module isodns_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Not-found results carry an all-zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("not-found result with nonzero payload");

  // Input backpressure only while the result register is full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

endmodule

bind iso9660_directory_name_search_core isodns_checker u_isodns_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

import isodns_pkg::*;

typedef logic [7:0] octets_t[$];
typedef logic [8:0] feed_t;  // {first_of_scan, dir_byte}

// Directory record lookup predictor plus the queue of results it still owes.
class dir_lookup_model;
  // configuration copy
  logic [31:0]  dir_size;
  logic [5:0]   want_len;
  logic [63:0]  want_chars[4];
  // scan state
  logic [31:0]  offset;
  int unsigned  rec_pos;
  int unsigned  rec_len;
  bit           skip_pad;
  logic [31:0]  ent_sector;
  logic [31:0]  ent_bytes;
  bit           ent_dir;
  int unsigned  ent_nlen;
  logic [7:0]   ent_first;
  bit           name_ok;
  bit           ver_mark;
  bit           idle;
  // bookkeeping
  result_t      hits[$];
  int unsigned  errors;
  int unsigned  live_bytes;
  int unsigned  scans_closed;

  function new();
    dir_size   = '0;
    want_len   = 6'd1;
    foreach (want_chars[k]) want_chars[k] = '0;
    offset     = '0;
    rec_pos    = 0;
    rec_len    = 0;
    skip_pad   = 0;
    ent_sector = '0;
    ent_bytes  = '0;
    ent_dir    = 0;
    ent_nlen   = 0;
    ent_first  = '0;
    name_ok    = 1;
    ver_mark   = 0;
    idle       = 1;
    errors     = 0;
    live_bytes = 0;
    scans_closed = 0;
  endfunction

  static function logic [7:0] upcase(logic [7:0] c);
    if (c >= CHAR_LC_A && c <= CHAR_LC_Z) return c - CASE_DELTA;
    return c;
  endfunction

  function logic [7:0] want_char(int unsigned i);
    logic [63:0] w;
    w = want_chars[(i / 8) % 4];
    return w[8 * (i % 8) +: 8];
  endfunction

  function int pending();
    return hits.size();
  endfunction

  function void set_reg(logic [2:0] idx, logic [63:0] v);
    case (idx)
      CFG_DIR_SIZE: dir_size      = v[31:0];
      CFG_NAME_LEN: want_len      = v[5:0];
      CFG_CHARS_0:  want_chars[0] = v;
      CFG_CHARS_8:  want_chars[1] = v;
      CFG_CHARS_16: want_chars[2] = v;
      CFG_CHARS_24: want_chars[3] = v;
      default: ;
    endcase
  endfunction

  function void complain(string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endfunction

  // offset saturates instead of wrapping
  function void bump();
    if (offset != '1) offset++;
  endfunction

  function void close_scan(bit f, logic [31:0] sec, logic [31:0] sz, bit dir);
    result_t r;
    r.found  = f;
    r.sector = sec;
    r.bytes  = sz;
    r.is_dir = dir;
    hits.push_back(r);
    idle = 1;
    scans_closed++;
  endfunction

  function void note_byte(logic [7:0] b, logic first);
    bit          boundary;
    bit          decide;
    bit          dot;
    int unsigned p;
    int unsigned nl;
    int unsigned i;
    int unsigned eff;
    boundary = 0;
    if (first) begin
      offset   = '0;
      rec_pos  = 0;
      rec_len  = 0;
      skip_pad = 0;
      name_ok  = 1;
      ver_mark = 0;
      idle     = 0;
    end else if (idle) begin
      return;
    end
    live_bytes++;

    if (skip_pad) begin
      bump();
      if (offset % SECTOR_BYTES_DEF == 0 || offset == '1) begin
        skip_pad = 0;
        boundary = 1;
      end
    end else if (rec_pos == 0) begin
      if (offset >= dir_size) begin
        close_scan(0, '0, '0, 0);
        return;
      end
      bump();
      if (b == 0) begin
        if (offset % SECTOR_BYTES_DEF != 0 && offset != '1) skip_pad = 1;
        else boundary = 1;
      end else begin
        rec_len    = b;
        ent_sector = '0;
        ent_bytes  = '0;
        ent_dir    = 0;
        ent_nlen   = 0;
        ent_first  = '0;
        name_ok    = 1;
        ver_mark   = 0;
        if (b == 1) boundary = 1;
        else rec_pos = 1;
      end
    end else begin
      p      = rec_pos;
      nl     = ent_nlen;
      decide = 0;
      if (p >= POS_SECTOR_LO && p <= POS_SECTOR_HI) begin
        ent_sector |= 32'(b) << (8 * (p - POS_SECTOR_LO));
      end else if (p >= POS_SIZE_LO && p <= POS_SIZE_HI) begin
        ent_bytes |= 32'(b) << (8 * (p - POS_SIZE_LO));
      end else if (p == POS_FLAGS) begin
        ent_dir = b[DIR_FLAG_BIT];
      end else if (p == POS_NAME_LEN) begin
        ent_nlen = b;
        nl       = b;
        if (nl == 0) decide = 1;
      end else if (p >= POS_NAME && p < POS_NAME + nl) begin
        i = p - POS_NAME;
        if (i == 0) ent_first = b;
        if (nl >= 2 && i == nl - 2 && b == CHAR_SEMI) begin
          ver_mark = 1;
        end else if (ver_mark && i == nl - 1) begin
          // version digit is left out of the compare
        end else if (i >= want_len || i >= MAX_NAME_CHARS ||
                     upcase(b) != upcase(want_char(i))) begin
          name_ok = 0;
        end
        if (p == POS_NAME + nl - 1) decide = 1;
      end
      bump();
      if (decide) begin
        dot = (nl == 1 && ent_first <= 1);
        eff = ver_mark ? nl - 2 : nl;
        if (!dot && name_ok && eff == want_len && want_len <= MAX_NAME_CHARS) begin
          close_scan(1, ent_sector, ent_bytes, ent_dir);
          return;
        end
      end
      if (p + 1 >= rec_len) begin
        rec_pos  = 0;
        boundary = 1;
      end else begin
        rec_pos = p + 1;
      end
    end

    if (boundary && offset >= dir_size) close_scan(0, '0, '0, 0);
  endfunction

  function void check_result(logic found, logic [71:0] data);
    result_t got;
    result_t want;
    got.found  = found;
    got.sector = data[31:0];
    got.bytes  = data[63:32];
    got.is_dir = data[64];
    if (hits.size() == 0) begin
      complain($sformatf("unexpected result found=%0b sector=%h bytes=%h dir=%0b",
                         got.found, got.sector, got.bytes, got.is_dir));
      return;
    end
    want = hits.pop_front();
    if (got.found !== want.found || got.sector !== want.sector ||
        got.bytes !== want.bytes || got.is_dir !== want.is_dir) begin
      complain($sformatf("expected found=%0b sector=%h bytes=%h dir=%0b, got %0b %h %h %0b",
                         want.found, want.sector, want.bytes, want.is_dir,
                         got.found, got.sector, got.bytes, got.is_dir));
    end
  endfunction
endclass

module tb;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int RX_HOLD        = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 8;     // settling wait after the last result
  localparam int RANDOM_BYTES   = 1850;
  localparam int RANDOM_SCANS   = 40;

  typedef enum {NM_MATCH, NM_NEAR, NM_DOT, NM_JUNK} name_kind_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;   // [31:0] entry_sector, [63:32] entry_bytes, [64] entry_is_dir
  logic        m_axis_tuser;   // [0] found
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = CFG_DIR_SIZE;
  logic [63:0] cfg_wdata_i   = '0;

  dir_lookup_model lookup;
  bit tx_calm;          // sender runs without gaps
  bit random_phase;     // random stimulus under way
  bit long_hold_done;

  iso9660_directory_name_search_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Sample both handshakes at the rising edge; drivers only move on the falling one.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      lookup.note_byte(s_axis_tdata, s_axis_tuser);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      lookup.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // Watchdog: end the run if neither side moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, calm stretches, and one long hold-off while a result
  // waits so the core backs up and stalls its byte input.
  initial begin : result_sink
    int g;
    int calm_left;
    bit calm;
    calm_left = 0;
    calm      = 0;
    forever begin
      @(negedge clk_i);
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 300);
      end else begin
        calm_left--;
      end
      if (!long_hold_done && random_phase && lookup.pending() != 0) begin
        long_hold_done = 1;
        m_axis_tready  = 1'b0;
        repeat (RX_HOLD) @(negedge clk_i);
      end
      g = calm ? 0 : gap_len();
      if (g > 0) begin
        m_axis_tready = 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  // Offer one byte, hold it until taken, then drop valid at the next falling edge.
  task automatic push_byte(input logic [7:0] b, input logic first);
    int g;
    g = tx_calm ? 0 : gap_len();
    if (g > 0) repeat (g) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = first;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (lookup.pending() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_put(input logic [2:0] idx, input logic [63:0] v);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = v;
    lookup.set_reg(idx, v);
    @(negedge clk_i);
  endtask

  // Program a search; chars: 0 keep, 1 random, 2 all ones.
  // Random characters skip 0x00, 0x01 and ';' so a copied name can always match.
  task automatic configure(input logic [31:0] ds, input logic [5:0] nl, input int chars);
    logic [63:0] v;
    logic [7:0]  c;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_put(CFG_DIR_SIZE, {32'($urandom), ds});
    cfg_put(CFG_NAME_LEN, {32'($urandom), 26'($urandom), nl});
    if (chars != 0) begin
      for (int k = 0; k < 4; k++) begin
        for (int j = 0; j < 8; j++) begin
          c = 8'($urandom);
          if (chars == 2) begin
            c = 8'hFF;
          end else if ($urandom_range(0, 1)) begin
            c = 8'($urandom_range(0, 25)) + (($urandom_range(0, 1)) ? CHAR_LC_A : 8'h41);
          end else if (c <= 8'h01 || c == CHAR_SEMI) begin
            c = c + 8'h40;
          end
          v[8 * j +: 8] = c;
        end
        cfg_put(3'(CFG_CHARS_0 + k), v);
      end
    end
    cfg_we_i = 1'b0;
  endtask

  // Copy of the searched component with random letter case, optionally ";v".
  function automatic octets_t match_name(bit with_ver);
    octets_t     n;
    logic [7:0]  c;
    for (int k = 0; k < lookup.want_len; k++) begin
      c = (k < MAX_NAME_CHARS) ? lookup.want_char(k) : 8'($urandom);
      if (fold_case(c) >= 8'h41 && fold_case(c) <= 8'h5A &&
          $urandom_range(0, 1)) begin
        c = c ^ CASE_DELTA;
      end
      n.push_back(c);
    end
    if (with_ver) begin
      n.push_back(CHAR_SEMI);
      n.push_back(8'($urandom));
    end
    return n;
  endfunction

  function automatic octets_t pick_name(name_kind_e kind);
    octets_t    n;
    logic [7:0] c;
    int         idx;
    case (kind)
      NM_MATCH: n = match_name($urandom_range(0, 1));
      NM_NEAR: begin
        n = match_name($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: if (n.size() > 0) begin
            idx = $urandom_range(0, n.size() - 1);
            c   = 8'($urandom);
            if (fold_case(c) == fold_case(n[idx])) begin
              c = n[idx] ^ 8'h01;
            end
            n[idx] = c;
          end
          1: if (n.size() > 0) void'(n.pop_back());
          2: n.push_back(8'($urandom_range(0, 25)) + CHAR_LC_A);
          default: if (n.size() >= 2) n[n.size() - 2] = CHAR_SEMI;
        endcase
      end
      NM_DOT: n.push_back(8'($urandom_range(0, 1)));
      default: begin
        repeat ($urandom_range(0, 40)) begin
          c = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 25)) + CHAR_LC_A
                                          : 8'($urandom);
          n.push_back(c);
        end
      end
    endcase
    return n;
  endfunction

  // Append one directory record; a cut record ends before its name does.
  function automatic void add_record(ref feed_t q[$], input octets_t name,
                                     input logic [31:0] sec, input logic [31:0] sz,
                                     input logic dir, input bit cut);
    logic [7:0] rec[$];
    int         len;
    int         nl;
    nl  = name.size();
    len = POS_NAME + nl + ((nl % 2 == 0) ? 1 : 0);
    for (int k = 0; k < len; k++) rec.push_back(8'($urandom));
    rec[1] = 8'h00;
    for (int k = 0; k < 4; k++) begin
      rec[POS_SECTOR_LO + k] = sec[8 * k +: 8];
      rec[POS_SECTOR_LO + 7 - k] = sec[8 * k +: 8];
      rec[POS_SIZE_LO + k] = sz[8 * k +: 8];
      rec[POS_SIZE_LO + 7 - k] = sz[8 * k +: 8];
    end
    rec[POS_FLAGS][DIR_FLAG_BIT] = dir;
    rec[POS_NAME_LEN] = 8'(nl);
    for (int k = 0; k < nl; k++) rec[POS_NAME + k] = name[k];
    if (cut) len = $urandom_range(2, POS_NAME + nl - 1);
    rec[0] = 8'(len);
    for (int k = 0; k < len; k++) q.push_back({1'b0, rec[k]});
  endfunction

  // Feed one scan until the core owes its result; when the prepared bytes run out,
  // finish the current record or padding, then close the extent with one-byte
  // records, or with a matching record where the extent is far too long.
  task automatic run_scan(input feed_t q[$]);
    int k;
    k    = 0;
    q[0] = {1'b1, q[0][7:0]};
    do begin
      if (k == q.size()) begin
        if (lookup.skip_pad || lookup.rec_pos != 0) begin
          q.push_back({1'b0, 8'($urandom)});
        end else if (lookup.want_len <= MAX_NAME_CHARS && lookup.dir_size > lookup.offset &&
                     lookup.dir_size - lookup.offset > 300) begin
          add_record(q, match_name($urandom_range(0, 1)), $urandom, $urandom,
                     $urandom_range(0, 1), 0);
        end else begin
          q.push_back(9'h001);
        end
      end
      push_byte(q[k][7:0], q[k][8]);
      k++;
    end while (!lookup.idle);
  endtask

  task automatic random_scan();
    feed_t      q[$];
    int         start;
    int         r;
    name_kind_e kind;
    repeat ($urandom_range(1, 4)) begin
      start = q.size();
      r     = $urandom_range(0, 99);
      if (r < 3) begin
        q.push_back(9'h000);        // zero length byte: pad to the sector end
      end else if (r < 7) begin
        q.push_back(9'h001);        // one-byte record
      end else begin
        r    = $urandom_range(0, 99);
        kind = (r < 25) ? NM_MATCH : (r < 50) ? NM_NEAR : (r < 62) ? NM_DOT : NM_JUNK;
        add_record(q, pick_name(kind), $urandom, $urandom, $urandom_range(0, 1),
                   $urandom_range(0, 9) == 0);
      end
      if (start > 0 && $urandom_range(0, 19) == 0) q[start] = {1'b1, q[start][7:0]};
    end
    run_scan(q);
    // trailing bytes while the core is idle are dropped
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom), 1'b0);
  endtask

  initial begin : stimulus
    feed_t       q[$];
    int unsigned base;
    logic [31:0] ds;
    logic [5:0]  nl;
    int          r;
    lookup = new();
    tx_calm = 0;
    random_phase = 0;
    long_hold_done = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Idle after reset: bytes without the scan start are dropped; an empty extent
    // answers not-found on its first byte.
    repeat (3) push_byte(8'($urandom), 1'b0);
    q = {};
    q.push_back(9'h022);
    run_scan(q);

    // Self and parent entries, a junk name, then a match with a version suffix.
    configure(32'd300, 6'd8, 1);
    q = {};
    add_record(q, pick_name(NM_DOT), 32'h0000_0001, 32'h0000_0800, 1, 0);
    add_record(q, pick_name(NM_DOT), 32'h0000_0002, 32'h0000_0800, 1, 0);
    add_record(q, pick_name(NM_JUNK), 32'h1234_5678, 32'h9ABC_DEF0, 0, 0);
    add_record(q, match_name(1), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0);
    run_scan(q);
    // near misses before a plain match
    q = {};
    repeat (3) add_record(q, pick_name(NM_NEAR), $urandom, $urandom, 0, 0);
    add_record(q, match_name(0), 32'h0000_0000, 32'h0000_0000, 0, 0);
    run_scan(q);

    // A record that starts inside a short extent runs past its end and still matches;
    // a cut record never matches.
    configure(32'd40, 6'd8, 0);
    q = {};
    add_record(q, match_name(1), $urandom, $urandom, 1, 0);
    run_scan(q);
    q = {};
    add_record(q, match_name(0), $urandom, $urandom, 1, 1);
    run_scan(q);

    // Empty component: matches an empty name or a bare version.
    configure(32'd120, 6'd0, 0);
    q = {};
    add_record(q, pick_name(NM_JUNK), $urandom, $urandom, 0, 0);
    add_record(q, match_name(0), $urandom, $urandom, 1, 0);
    run_scan(q);
    q = {};
    add_record(q, match_name(1), $urandom, $urandom, 0, 0);
    run_scan(q);

    // Component longer than the compare window never matches.
    configure(32'd120, 6'd63, 1);
    q = {};
    add_record(q, match_name(0), $urandom, $urandom, 0, 0);
    run_scan(q);

    // Largest extent, all-ones characters: zero length byte pads to the sector end,
    // then a restart in the middle of a record.
    configure(32'hFFFF_FFFF, 6'd32, 2);
    q = {};
    add_record(q, pick_name(NM_JUNK), $urandom, $urandom, 0, 0);
    q.push_back(9'h000);
    run_scan(q);
    q = {};
    add_record(q, pick_name(NM_JUNK), $urandom, $urandom, 0, 0);
    q = q[0:9];
    base = q.size();
    add_record(q, match_name(0), $urandom, $urandom, 1, 0);
    q[base] = {1'b1, q[base][7:0]};
    run_scan(q);

    configure(32'hFFFF_FFFF, 6'd1, 1);
    q = {};
    add_record(q, pick_name(NM_DOT), $urandom, $urandom, 1, 0);
    add_record(q, match_name(1), $urandom, $urandom, 1, 0);
    run_scan(q);

    // Random phases: new search settings, then a handful of scans each.
    random_phase = 1;
    base = lookup.live_bytes;
    r    = lookup.scans_closed;
    while (lookup.live_bytes - base < RANDOM_BYTES || lookup.scans_closed - r < RANDOM_SCANS) begin
      case ($urandom_range(0, 9))
        0: nl = 6'd0;
        1: nl = 6'($urandom_range(33, 63));
        2: nl = 6'd32;
        default: nl = 6'($urandom_range(1, 31));
      endcase
      case ($urandom_range(0, 9))
        0: ds = 32'd0;
        1: ds = (nl <= MAX_NAME_CHARS) ? 32'hFFFF_FFFF : 32'd200;
        default: ds = 32'($urandom_range(20, 300));
      endcase
      configure(ds, nl, ($urandom_range(0, 9) < 7) ? 1 : 0);
      repeat ($urandom_range(2, 5)) begin
        tx_calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 9) == 0) wait_drained();
        random_scan();
      end
    end

    // Drain: everything owed must arrive, then let the pipeline settle.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (lookup.pending() != 0) lookup.complain("results still owed at the end");
    if (lookup.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/isodns_pkg.sv
design/isodns_name_cmp.sv
design/isodns_parser.sv
design/iso9660_directory_name_search_core.sv
design/isodns_checker.sv
tb/sv/tb.sv
